[hdl/fmap_pkg.sv]
// Shared types, codes and microcode layout for the four-level page table map unit.
`timescale 1ns / 1ps
package fmap_pkg;

	localparam int POOL_PAGES_DEF = 64;
	localparam int IDX_W          = 9;
	localparam int FRAME_W        = 40;
	localparam int CFG_W          = 52;
	localparam int PC_W           = 4;

	localparam logic [FRAME_W-1:0] BASE_RESET = 40'h0_0000_0200;
	localparam logic [1:0]         LAST_LEVEL = 2'd2;

	localparam logic [1:0] STATUS_MAPPED   = 2'd0;
	localparam logic [1:0] STATUS_NONCANON = 2'd1;
	localparam logic [1:0] STATUS_NO_POOL  = 2'd2;

	// microprogram step labels
	localparam logic [PC_W-1:0] ST_CLR     = 4'd0;
	localparam logic [PC_W-1:0] ST_IDLE    = 4'd1;
	localparam logic [PC_W-1:0] ST_CHK     = 4'd2;
	localparam logic [PC_W-1:0] ST_RD      = 4'd3;
	localparam logic [PC_W-1:0] ST_EVAL    = 4'd4;
	localparam logic [PC_W-1:0] ST_POOLCHK = 4'd5;
	localparam logic [PC_W-1:0] ST_ALLOC   = 4'd6;
	localparam logic [PC_W-1:0] ST_RESOLVE = 4'd7;
	localparam logic [PC_W-1:0] ST_MOD     = 4'd8;
	localparam logic [PC_W-1:0] ST_MODQ    = 4'd9;
	localparam logic [PC_W-1:0] ST_MODEND  = 4'd10;
	localparam logic [PC_W-1:0] ST_NEXT    = 4'd11;
	localparam logic [PC_W-1:0] ST_LEAF    = 4'd12;
	localparam logic [PC_W-1:0] ST_FCANON  = 4'd13;
	localparam logic [PC_W-1:0] ST_FPOOL   = 4'd14;
	localparam logic [PC_W-1:0] ST_DONE    = 4'd15;

	typedef enum logic [3:0] {
		ACT_NONE    = 4'd0,
		ACT_CLEAR   = 4'd1,
		ACT_LATCH   = 4'd2,
		ACT_READ    = 4'd3,
		ACT_OFFSET  = 4'd4,
		ACT_ALLOC   = 4'd5,
		ACT_RESOLVE = 4'd6,
		ACT_MOD     = 4'd7,
		ACT_MODEND  = 4'd8,
		ACT_NEXT    = 4'd9,
		ACT_LEAF    = 4'd10,
		ACT_CANON   = 4'd11,
		ACT_POOL    = 4'd12,
		ACT_RESULT  = 4'd13,
		ACT_QUOT    = 4'd14
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER      = 4'd0,
		C_ALWAYS     = 4'd1,
		C_NO_START   = 4'd2,
		C_CLR_BUSY   = 4'd3,
		C_NONCANON   = 4'd4,
		C_PRESENT    = 4'd5,
		C_POOL_EMPTY = 4'd6,
		C_IN_RANGE   = 4'd7,
		C_NOT_LAST   = 4'd8
	} cond_t;

	typedef struct packed {
		act_t            act;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic clr_busy;
		logic noncanon;
		logic present;
		logic pool_empty;
		logic in_range;
		logic not_last;
	} flags_t;

endpackage

[hdl/fmap_seq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module fmap_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fmap_pkg::flags_t flags,
	output fmap_pkg::ctrl_t  ctrl,
	output logic           busy
);
	import fmap_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            take;

	function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			ST_CLR:     w = '{ACT_CLEAR,   C_CLR_BUSY,   ST_CLR};
			ST_IDLE:    w = '{ACT_LATCH,   C_NO_START,   ST_IDLE};
			ST_CHK:     w = '{ACT_NONE,    C_NONCANON,   ST_FCANON};
			ST_RD:      w = '{ACT_READ,    C_NEVER,      ST_IDLE};
			ST_EVAL:    w = '{ACT_OFFSET,  C_PRESENT,    ST_RESOLVE};
			ST_POOLCHK: w = '{ACT_NONE,    C_POOL_EMPTY, ST_FPOOL};
			ST_ALLOC:   w = '{ACT_ALLOC,   C_ALWAYS,     ST_NEXT};
			ST_RESOLVE: w = '{ACT_RESOLVE, C_IN_RANGE,   ST_NEXT};
			ST_MOD:     w = '{ACT_MOD,     C_NEVER,      ST_IDLE};
			ST_MODQ:    w = '{ACT_QUOT,    C_NEVER,      ST_IDLE};
			ST_MODEND:  w = '{ACT_MODEND,  C_NEVER,      ST_IDLE};
			ST_NEXT:    w = '{ACT_NEXT,    C_NOT_LAST,   ST_RD};
			ST_LEAF:    w = '{ACT_LEAF,    C_ALWAYS,     ST_DONE};
			ST_FCANON:  w = '{ACT_CANON,   C_ALWAYS,     ST_DONE};
			ST_FPOOL:   w = '{ACT_POOL,    C_NEVER,      ST_IDLE};
			ST_DONE:    w = '{ACT_RESULT,  C_ALWAYS,     ST_IDLE};
			default:    w = '{ACT_NONE,    C_ALWAYS,     ST_IDLE};
		endcase
		return w;
	endfunction

	assign ctrl = rom(pc_q);
	assign busy = (pc_q != ST_IDLE);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_START:   take = !start;
			C_CLR_BUSY:   take = flags.clr_busy;
			C_NONCANON:   take = flags.noncanon;
			C_PRESENT:    take = flags.present;
			C_POOL_EMPTY: take = flags.pool_empty;
			C_IN_RANGE:   take = flags.in_range;
			C_NOT_LAST:   take = flags.not_last;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_CLR;
		end else begin
			pc_q <= take ? ctrl.target : pc_q + PC_W'(1);
		end
	end

endmodule

[hdl/fmap_dp.sv]
// Datapath: table store, walk registers, pool allocator and constant modulo.
`timescale 1ns / 1ps
module fmap_dp #(
	parameter int POOL_PAGES = fmap_pkg::POOL_PAGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fmap_pkg::ctrl_t           ctrl,
	output fmap_pkg::flags_t          flags,
	input  logic [63:0]               virt_addr,
	input  logic [63:0]               phys_addr,
	input  logic [63:0]               entry_flags,
	input  logic                      cfg_valid,
	input  logic [fmap_pkg::CFG_W-1:0] cfg_data,
	output logic                      done,
	output logic [1:0]                status,
	output logic [1:0]                tables_created
);
	import fmap_pkg::*;

	localparam int TW     = $clog2(POOL_PAGES + 1);
	localparam int AW     = TW + IDX_W;
	localparam int DEPTH  = (POOL_PAGES + 1) * 512;
	localparam int MOD_L  = $clog2(POOL_PAGES);
	localparam int FOLD_W = 21;
	localparam int PROD_W = FOLD_W + 22;

	// 2^(10j) mod pool pages, one per 10-bit chunk of the offset
	localparam logic [9:0]  FOLD_R0 = 10'(1 % POOL_PAGES);
	localparam logic [9:0]  FOLD_R1 = 10'((1 << 10) % POOL_PAGES);
	localparam logic [9:0]  FOLD_R2 = 10'((1 << 20) % POOL_PAGES);
	localparam logic [9:0]  FOLD_R3 = 10'((1 << 30) % POOL_PAGES);
	localparam logic [21:0] RECIP   = 22'(((64'd1 << (FOLD_W + MOD_L)) +
	                                        64'(POOL_PAGES) - 64'd1) / 64'(POOL_PAGES));
	localparam logic [9:0]  POOL_N  = 10'(POOL_PAGES);

	logic [63:0]        mem [DEPTH];
	logic [63:0]        rd_q;
	logic [63:0]        va_q, pa_q, fl_q;
	logic [FRAME_W-1:0] base_q, off_q;
	logic [AW-1:0]      clr_q, slot_q, mem_addr;
	logic [TW-1:0]      table_q, nfp_q;
	logic [1:0]         level_q, created_q, status_q;
	logic [FOLD_W-1:0]  fold_q, fold_d;
	logic [PROD_W-1:0]  prod;
	logic [9:0]         quo_q, quo_d, rem_d;
	logic [IDX_W-1:0]   idx;
	logic [FRAME_W:0]   alloc_frame;
	logic [63:0]        wdata;
	logic               we;

	always_comb begin
		unique case (level_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			default: idx = va_q[29:21];
		endcase
	end

	assign alloc_frame = {1'b0, base_q} + (FRAME_W + 1)'(nfp_q);

	always_comb begin
		mem_addr = slot_q;
		wdata    = '0;
		we       = 1'b0;
		unique case (ctrl.act)
			ACT_CLEAR: begin
				mem_addr = clr_q;
				we       = 1'b1;
			end
			ACT_READ: mem_addr = {table_q, idx};
			ACT_ALLOC: begin
				wdata = {11'd0, alloc_frame, 12'h003};
				we    = 1'b1;
			end
			ACT_LEAF: begin
				mem_addr = {table_q, va_q[20:12]};
				wdata    = {12'd0, pa_q[51:12], 12'd0} | fl_q | 64'd1;
				we       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[mem_addr] <= wdata;
		end
		if (ctrl.act == ACT_READ) begin
			rd_q <= mem[mem_addr];
		end
	end

	// offset mod pool pages: fold the 10-bit chunks, then reciprocal quotient
	assign fold_d = FOLD_W'(off_q[9:0])   * FOLD_W'(FOLD_R0) +
	                FOLD_W'(off_q[19:10]) * FOLD_W'(FOLD_R1) +
	                FOLD_W'(off_q[29:20]) * FOLD_W'(FOLD_R2) +
	                FOLD_W'(off_q[39:30]) * FOLD_W'(FOLD_R3);
	assign prod   = PROD_W'(fold_q) * PROD_W'(RECIP);
	assign quo_d  = 10'(prod >> (FOLD_W + MOD_L));
	assign rem_d  = fold_q[9:0] - quo_q * POOL_N;

	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ACT_LATCH: begin
				va_q <= virt_addr;
				pa_q <= phys_addr;
				fl_q <= entry_flags;
			end
			ACT_READ:   slot_q <= {table_q, idx};
			ACT_OFFSET: off_q  <= rd_q[51:12] - base_q;
			ACT_MOD:    fold_q <= fold_d;
			ACT_QUOT:   quo_q  <= quo_d;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RESET;
			clr_q     <= '0;
			table_q   <= '0;
			nfp_q     <= '0;
			level_q   <= '0;
			created_q <= '0;
			status_q  <= STATUS_MAPPED;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data[51:12];
			end
			unique case (ctrl.act)
				ACT_CLEAR: clr_q <= clr_q + AW'(1);
				ACT_LATCH: begin
					table_q   <= '0;
					level_q   <= '0;
					created_q <= '0;
					status_q  <= STATUS_MAPPED;
				end
				ACT_ALLOC: begin
					table_q   <= nfp_q + TW'(1);
					nfp_q     <= nfp_q + TW'(1);
					created_q <= created_q + 2'd1;
				end
				ACT_RESOLVE: table_q  <= TW'(off_q) + TW'(1);
				ACT_MODEND:  table_q  <= TW'(rem_d) + TW'(1);
				ACT_NEXT:    level_q  <= level_q + 2'd1;
				ACT_CANON:   status_q <= STATUS_NONCANON;
				ACT_POOL:    status_q <= STATUS_NO_POOL;
				default: ;
			endcase
		end
	end

	assign flags.clr_busy   = (clr_q != AW'(DEPTH - 1));
	assign flags.noncanon   = !((va_q[63:47] == '0) || (va_q[63:47] == '1));
	assign flags.present    = rd_q[0];
	assign flags.pool_empty = (nfp_q == TW'(POOL_PAGES));
	assign flags.in_range   = (off_q < FRAME_W'(POOL_PAGES));
	assign flags.not_last   = (level_q != LAST_LEVEL);

	assign done           = (ctrl.act == ACT_RESULT);
	assign status         = status_q;
	assign tables_created = created_q;

endmodule

[hdl/four_level_page_table_map_unit.sv]
// Top level of the four-level page table map unit.
// After reset the table store is cleared one entry per cycle, with busy high, until
// all (POOL_PAGES + 1) * 512 entries (33280 at the default) are zero; configuration
// writes are taken throughout. A request is taken when start is high and busy is low.
// A non-canonical address goes straight to the result; otherwise each level reads its
// entry and either follows a present entry or allocates a fresh table, and the leaf
// is written after the last level. A present entry that points outside the pool
// under the current base adds the modulo steps (MOD, MODQ, MODEND). A request that
// finds the pool empty stops at that level and goes to the result. The table store
// is single-port, and each level's read must return before the next address is
// known. The result shows on status and tables_created for exactly one cycle while
// done is high; it cannot be held off, so the receiver must take it then. cfg_ready
// is always high.
`timescale 1ns / 1ps
module four_level_page_table_map_unit #(
	parameter int POOL_PAGES = fmap_pkg::POOL_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [63:0]                virt_addr,
	input  logic [63:0]                phys_addr,
	input  logic [63:0]                entry_flags,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [1:0]                 tables_created,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fmap_pkg::CFG_W-1:0] cfg_data
);
	import fmap_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	assign cfg_ready = 1'b1;

	fmap_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	fmap_dp #(
		.POOL_PAGES (POOL_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.flags          (flags),
		.virt_addr      (virt_addr),
		.phys_addr      (phys_addr),
		.entry_flags    (entry_flags),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.tables_created (tables_created)
	);

endmodule

[sim/four_level_page_table_map_unit_tb.sv]
// Testbench for the four-level page table map unit: table-walk predictor, scoreboard, stimulus.
`timescale 1ns / 1ps
module four_level_page_table_map_unit_tb;
	import fmap_pkg::*;

	localparam int          POOL         = POOL_PAGES_DEF;
	localparam int          ENTRIES      = 512;
	localparam int          STORE_DEPTH  = (POOL + 1) * ENTRIES;
	localparam int          LIMIT_CYCLES = 1_200_000;
	localparam int          SETTLE       = 200;
	localparam logic [63:0] PFN_MASK     = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] PTE_PRESENT  = 64'h1;
	localparam logic [63:0] PTE_WRITABLE = 64'h2;

	typedef enum logic [1:0] {OP_MAP, OP_BASE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t    kind;
		logic [63:0] va;
		logic [63:0] pa;
		logic [63:0] fl;
		logic [51:0] base;
		int          idle_pct;
	} map_op_t;

	typedef struct {
		logic [1:0] status;
		logic [1:0] tables;
	} map_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [63:0]        virt_addr = '0;
	logic [63:0]        phys_addr = '0;
	logic [63:0]        entry_flags = '0;
	logic               done;
	logic [1:0]         status;
	logic [1:0]         tables_created;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data = '0;

	// predictor state, zero from the start like the cleared store
	bit   [63:0]        page_tables [0:STORE_DEPTH-1];
	int unsigned        pages_taken = 0;
	logic [51:0]        pool_base_q = 52'h20_0000;

	map_op_t            op_q [$];
	map_result_t        pending_results [$];
	logic [26:0]        routes [$];

	int                 accepted_cnt = 0;
	int                 results_got = 0;
	int                 err_cnt = 0;
	int                 base_writes = 0;
	int                 cnt_mapped = 0;
	int                 cnt_noncanon = 0;
	int                 cnt_no_pool = 0;
	int                 cyc = 0;

	map_op_t            cur;
	map_result_t        got;
	map_result_t        want;
	logic               drv_hold;
	logic               drv_start;
	logic               drv_cfg;

	four_level_page_table_map_unit #(.POOL_PAGES(POOL)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.virt_addr      (virt_addr),
		.phys_addr      (phys_addr),
		.entry_flags    (entry_flags),
		.done           (done),
		.status         (status),
		.tables_created (tables_created),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #4 clk = ~clk;

	// Walks root, PDPT and PD, allocating missing tables, then writes the leaf.
	function automatic void walk_and_map(input logic [63:0] va, input logic [63:0] pa,
			input logic [63:0] fl, output logic [1:0] st, output logic [1:0] tc);
		logic [16:0] top_bits;
		logic [63:0] base_fr;
		logic [63:0] ent;
		logic [63:0] pg_off;
		logic [8:0]  idx;
		int unsigned tbl;
		int unsigned made;
		int unsigned pg;
		top_bits = va[63:47];
		st = STATUS_MAPPED;
		tc = 2'd0;
		made = 0;
		tbl = 0;
		if (top_bits != '0 && top_bits != '1) begin
			st = STATUS_NONCANON;
			return;
		end
		base_fr = {12'h0, pool_base_q} & PFN_MASK;
		for (int lvl = 0; lvl < 3; lvl++) begin
			idx = 9'(va >> (39 - 9 * lvl));
			ent = page_tables[tbl * ENTRIES + idx];
			if (ent[0]) begin
				// entry may point outside the pool after a base change: fold it back in
				pg_off = (((ent & PFN_MASK) - base_fr) & PFN_MASK) >> 12;
				tbl = int'(pg_off % POOL) + 1;
			end else begin
				if (pages_taken >= POOL) begin
					st = STATUS_NO_POOL;
					tc = 2'(made);
					return;
				end
				pg = pages_taken;
				pages_taken++;
				page_tables[tbl * ENTRIES + idx] = (base_fr + (64'(pg) << 12)) |
					PTE_PRESENT | PTE_WRITABLE;
				tbl = pg + 1;
				made++;
			end
		end
		page_tables[tbl * ENTRIES + va[20:12]] = (pa & PFN_MASK) | fl | PTE_PRESENT;
		tc = 2'(made);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] make_va(logic [26:0] route, logic [8:0] leaf,
			logic [11:0] off);
		return {{16{route[26]}}, route, leaf, off};
	endfunction

	task automatic add_map(logic [63:0] va, logic [63:0] pa, logic [63:0] fl, int idle);
		map_op_t op;
		op.kind = OP_MAP;
		op.va = va;
		op.pa = pa;
		op.fl = fl;
		op.base = '0;
		op.idle_pct = idle;
		op_q.push_back(op);
	endtask

	task automatic add_ctl(op_kind_t kind, logic [51:0] base);
		map_op_t op;
		op.kind = kind;
		op.va = '0;
		op.pa = '0;
		op.fl = '0;
		op.base = base;
		op.idle_pct = 0;
		op_q.push_back(op);
	endtask

	// Mostly walks over known routes; some new routes, some malformed addresses.
	task automatic add_random(int n, int idle);
		logic [26:0] r;
		logic [63:0] va;
		int          pick;
		int          lvl;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			r = routes[$urandom_range(routes.size() - 1)];
			if (pick < 10) begin
				va = rand64();
			end else if (pick < 15) begin
				va = make_va(r, 9'($urandom), 12'($urandom)) ^
					(64'h1 << $urandom_range(63, 47));
			end else begin
				if (pick < 18) begin
					lvl = $urandom_range(2);
					r[lvl * 9 +: 9] = 9'($urandom);
					routes.push_back(r);
				end
				va = make_va(r, 9'($urandom), 12'($urandom));
			end
			add_map(va, rand64(), rand64(), idle);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			virt_addr   <= '0;
			phys_addr   <= '0;
			entry_flags <= '0;
			cfg_valid   <= 1'b0;
			cfg_data    <= '0;
		end else begin
			drv_hold = 1'b0;
			if (start && !busy) begin
				walk_and_map(virt_addr, phys_addr, entry_flags, got.status, got.tables);
				pending_results.push_back(got);
				accepted_cnt++;
			end else if (start) begin
				drv_hold = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				pool_base_q = cfg_data;
				base_writes++;
			end else if (cfg_valid) begin
				drv_hold = 1'b1;
			end
			if (!drv_hold) begin
				drv_start = 1'b0;
				drv_cfg = 1'b0;
				if (op_q.size() != 0) begin
					cur = op_q[0];
					case (cur.kind)
						OP_MAP: begin
							if ($urandom_range(99) >= cur.idle_pct) begin
								cur = op_q.pop_front();
								virt_addr   <= cur.va;
								phys_addr   <= cur.pa;
								entry_flags <= cur.fl;
								drv_start = 1'b1;
							end
						end
						OP_BASE: begin
							if (accepted_cnt == results_got) begin
								cur = op_q.pop_front();
								cfg_data <= cur.base;
								drv_cfg = 1'b1;
							end
						end
						default: begin
							if (accepted_cnt == results_got)
								cur = op_q.pop_front();
						end
					endcase
				end
				start     <= drv_start;
				cfg_valid <= drv_cfg;
			end
		end
	end

	// monitor: one result beat per done cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_got <= 0;
		end else if (done) begin
			results_got <= results_got + 1;
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status=%0d tables_created=%0d",
					status, tables_created);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				case (want.status)
					STATUS_MAPPED:   cnt_mapped++;
					STATUS_NONCANON: cnt_noncanon++;
					default:         cnt_no_pool++;
				endcase
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					err_cnt++;
				end
				if (tables_created !== want.tables) begin
					$error("tables_created: expected %0d, got %0d", want.tables,
						tables_created);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// directed: low bits of the base are junk and must be dropped
		add_ctl(OP_BASE, 52'h0_0000_0020_0ABC);
		add_map(64'h0, 64'h0, 64'h0, 0);
		add_map(make_va(27'h0, 9'h1FF, 12'hFFF), '1, '1, 0);
		add_map(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_1000, 64'h0, 0);
		add_map(64'h0000_7FFF_FFFF_F000, 64'hFFF0_0000_0000_0FFF, 64'h2, 0);
		add_map(64'hFFFF_8000_0000_0000, 64'h000F_FFFF_FFFF_F000, 64'h4, 0);
		add_map(64'h0000_8000_0000_0000, '1, '1, 0);
		add_map(64'hFFFF_7FFF_FFFF_FFFF, '1, '1, 0);
		add_map(64'h8000_0000_0000_0000, '1, '1, 0);
		add_map(64'h0001_0000_0000_0000, '1, '1, 0);
		add_map(make_va({9'h0, 9'h1, 9'h0}, 9'h0, 12'h0), rand64(), rand64(), 0);
		add_map(make_va({9'h0, 9'h0, 9'h5}, 9'h3, 12'h0), rand64(), rand64(), 0);
		add_map(make_va({9'h1FF, 9'h0, 9'h0}, 9'h0, 12'h0), rand64(), rand64(), 0);
		add_map(64'h0, 64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A4, 0);
		add_map(64'h0, 64'h0, 64'h8000_0000_0000_0006, 0);
		foreach (op_q[i])
			if (op_q[i].kind == OP_MAP && (op_q[i].va[63:47] == '0 || op_q[i].va[63:47] == '1))
				routes.push_back(op_q[i].va[47:21]);

		add_random(210, 0);
		add_ctl(OP_DRAIN, '0);
		add_random(210, 0);

		// base moves while tables exist, so old entries fold back into the pool
		add_ctl(OP_BASE, 52'hF_FFFF_FFFF_FFFF);
		add_random(180, 49);
		add_ctl(OP_DRAIN, '0);
		add_random(180, 49);

		add_ctl(OP_BASE, 52'h0);
		add_random(360, 22);

		add_ctl(OP_BASE, {20'($urandom), $urandom});
		add_random(180, 0);
		add_random(180, 22);
		// fresh routes at the tail drain whatever is left of the pool
		for (int i = 0; i < 25; i++)
			add_map(make_va(27'($urandom), 9'($urandom), 12'($urandom)), rand64(), rand64(), 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_q.size() != 0 || start || cfg_valid || accepted_cnt != results_got)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (pending_results.size() != 0)
			$error("%0d results never arrived", pending_results.size());
		$display("Covered %0d requests: %0d mapped, %0d non-canonical, %0d out of pool.",
			accepted_cnt, cnt_mapped, cnt_noncanon, cnt_no_pool);
		$display("%0d pool tables taken, %0d pool base writes.", pages_taken, base_writes);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/fmap_pkg.sv
hdl/fmap_seq.sv
hdl/fmap_dp.sv
hdl/four_level_page_table_map_unit.sv
sim/four_level_page_table_map_unit_tb.sv
